// ===== design/fdv_pkg.sv =====
package fdv_pkg;

   localparam int PIX_W       = 8;
   localparam int THR_W       = 14;
   localparam int FRAC_W      = 8;
   localparam int VAR_W       = 22;
   localparam int CNT_OUT_W   = 23;

   localparam logic [THR_W-1:0] THR_RESET = 14'd30;

   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

endpackage

// ===== design/fdv_if.sv =====
interface fdv_req_if import fdv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] new_pixel;
   logic [PIX_W-1:0] old_pixel;
   logic             last_pixel;

   modport source (output valid, output new_pixel, output old_pixel, output last_pixel,
                   input ready);
   modport sink   (input valid, input new_pixel, input old_pixel, input last_pixel,
                   output ready);
endinterface

interface fdv_rsp_if import fdv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VAR_W-1:0]     variance_q8;
   logic                 motion_detected;
   logic [CNT_OUT_W-1:0] pixel_count;

   modport source (output valid, output variance_q8, output motion_detected,
                   output pixel_count, input ready);
   modport sink   (input valid, input variance_q8, input motion_detected,
                   input pixel_count, output ready);
endinterface

// ===== design/fdv_front.sv =====
module fdv_front import fdv_pkg::*; #(
   parameter int MAX_PIXELS = 4194304,
   localparam int CNT_W = $clog2(MAX_PIXELS + 1),
   localparam int ABS_W = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1),
   localparam int SQ_W  = $clog2(64'(MAX_PIXELS) * 64'd65025 + 64'd1),
   localparam int TOT_W = CNT_W + ABS_W + SQ_W
) (
   input  logic             clock,
   input  logic             reset,
   fdv_req_if.sink          req_ch,
   output logic             q_push,
   output logic [TOT_W-1:0] q_data,
   input  logic             q_full
);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_sum;
   logic [ABS_W-1:0] abs_ff, abs_in, abs_sum;
   logic [SQ_W-1:0]  sq_ff, sq_in, sq_sum;
   logic [PIX_W-1:0] diff;
   logic [2*PIX_W-1:0] diff_sq;
   logic             room;
   logic             accept;

   assign req_ch.ready = !(req_ch.last_pixel && q_full);
   assign accept = req_ch.valid && req_ch.ready;
   assign room = cnt_ff < CNT_W'(MAX_PIXELS);

   always_comb begin
      diff = (req_ch.new_pixel >= req_ch.old_pixel) ? req_ch.new_pixel - req_ch.old_pixel
                                                    : req_ch.old_pixel - req_ch.new_pixel;
      diff_sq = diff * diff;
      cnt_sum = room ? cnt_ff + CNT_W'(1) : cnt_ff;
      abs_sum = room ? abs_ff + ABS_W'(diff) : abs_ff;
      sq_sum  = room ? sq_ff + SQ_W'(diff_sq) : sq_ff;
      cnt_in = cnt_ff;
      abs_in = abs_ff;
      sq_in  = sq_ff;
      if (accept) begin
         if (req_ch.last_pixel) begin
            cnt_in = '0;
            abs_in = '0;
            sq_in  = '0;
         end else begin
            cnt_in = cnt_sum;
            abs_in = abs_sum;
            sq_in  = sq_sum;
         end
      end
   end

   // frame totals include the closing beat
   assign q_push = accept && req_ch.last_pixel;
   assign q_data = {cnt_sum, abs_sum, sq_sum};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         abs_ff <= '0;
         sq_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         abs_ff <= abs_in;
         sq_ff  <= sq_in;
      end
   end

endmodule

// ===== design/fdv_queue.sv =====
module fdv_queue import fdv_pkg::*; #(
   parameter int WIDTH = 91
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]  mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == QCNT_W'(QDEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/fdv_back.sv =====
module fdv_back import fdv_pkg::*; #(
   parameter int MAX_PIXELS = 4194304,
   localparam int CNT_W = $clog2(MAX_PIXELS + 1),
   localparam int ABS_W = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1),
   localparam int SQ_W  = $clog2(64'(MAX_PIXELS) * 64'd65025 + 64'd1),
   localparam int TOT_W = CNT_W + ABS_W + SQ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  logic [TOT_W-1:0] q_data,
   output logic             q_pop,
   input  logic [THR_W-1:0] threshold,
   fdv_rsp_if.source        rsp_ch
);

   localparam int PW     = (CNT_W + SQ_W > 2 * ABS_W) ? CNT_W + SQ_W : 2 * ABS_W;
   localparam int OPW    = ABS_W;
   localparam int REMW   = PW + FRAC_W;
   localparam int DVW    = PW + VAR_W;
   localparam int NSTEP  = (OPW > VAR_W) ? OPW : VAR_W;
   localparam int STEP_W = $clog2(NSTEP);

   typedef enum logic [2:0] {
      S_IDLE, S_NQ, S_SS, S_NN, S_DIV, S_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [ABS_W-1:0]     s_ff, s_in;
   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [OPW-1:0]       mplier_ff, mplier_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        nq_ff, nq_in;
   logic [REMW-1:0]      rem_ff, rem_in;
   logic [DVW-1:0]       dsr_ff, dsr_in;
   logic [VAR_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 out_valid_ff, out_valid_in;
   logic [VAR_W-1:0]     var_ff, var_in;
   logic                 motion_ff, motion_in;
   logic [CNT_OUT_W-1:0] count_ff, count_in;

   logic [PW-1:0]        acc_add;
   logic [PW-1:0]        d_val;
   logic [DVW-1:0]       rem_ext, rem_sub;
   logic                 div_ge;
   logic [VAR_W-1:0]     thr_q8;
   logic                 out_take;

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.variance_q8     = var_ff;
   assign rsp_ch.motion_detected = motion_ff;
   assign rsp_ch.pixel_count     = count_ff;

   always_comb begin
      acc_add  = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      d_val    = (nq_ff >= acc_add) ? nq_ff - acc_add : '0;
      rem_ext  = DVW'(rem_ff);
      div_ge   = rem_ext >= dsr_ff;
      rem_sub  = rem_ext - dsr_ff;
      thr_q8   = VAR_W'({threshold, FRAC_W'(0)});
      out_take = !out_valid_ff || rsp_ch.ready;

      state_in     = state_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      nq_in        = nq_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      var_in       = var_ff;
      motion_in    = motion_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      q_pop        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               n_in      = q_data[TOT_W-1 -: CNT_W];
               s_in      = q_data[SQ_W +: ABS_W];
               mcand_in  = PW'(q_data[SQ_W-1:0]);
               mplier_in = OPW'(q_data[TOT_W-1 -: CNT_W]);
               acc_in    = '0;
               step_in   = STEP_W'(OPW - 1);
               state_in  = S_NQ;
            end
         end
         S_NQ, S_SS, S_NN: begin
            // one shift-add step of the shared multiplier
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            acc_in    = acc_add;
            step_in   = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               acc_in  = '0;
               step_in = STEP_W'(OPW - 1);
               case (state_ff)
                  S_NQ: begin
                     nq_in     = acc_add;
                     mcand_in  = PW'(s_ff);
                     mplier_in = s_ff;
                     state_in  = S_SS;
                  end
                  S_SS: begin
                     rem_in    = {d_val, FRAC_W'(0)};
                     mcand_in  = PW'(n_ff);
                     mplier_in = OPW'(n_ff);
                     state_in  = S_NN;
                  end
                  default: begin
                     dsr_in   = DVW'(acc_add) << (VAR_W - 1);
                     quo_in   = '0;
                     step_in  = STEP_W'(VAR_W - 1);
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_in = REMW'(rem_sub);
            end
            quo_in  = {quo_ff[VAR_W-2:0], div_ge};
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_take) begin
               var_in       = quo_ff;
               motion_in    = (quo_ff > thr_q8) || ((quo_ff == thr_q8) && (rem_ff != '0));
               count_in     = CNT_OUT_W'(n_ff);
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff      <= n_in;
      s_ff      <= s_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      nq_ff     <= nq_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      var_ff    <= var_in;
      motion_ff <= motion_in;
      count_ff  <= count_in;
   end

endmodule

// ===== design/frame_difference_variance_detector.sv =====
// frame difference variance detector
//
// req_ch takes one beat per cycle while ready is high: a new and an old pixel byte at the same
// position, with last_pixel on the final beat of a frame. Beats that do not
// close a frame are always taken. The closing beat snapshots the frame
// totals into a two-entry queue and clears the accumulators.
// rsp_ch gives one beat per frame: variance_q8 (variance of the absolute
// differences, 8 fraction bits), motion_detected (variance above
// csr threshold) and pixel_count.
// csr_wr_en / csr_wr_data write the motion threshold, reset value 30.
// The result comes from three passes through a shared one-bit-per-cycle
// multiplier with W-bit operands, W = bits of the absolute sum (30 at the
// default MAX_PIXELS), and a 22-step restoring divider. The result path
// takes the next frame from the queue only when done with the last; beats
// stream at one beat per cycle until two frames wait in the queue.
// Reset clears the accumulators, the queue and the result valid flag.
// A stalled rsp_ch holds its beat; the queue keeps taking frames until full,
// then only a closing beat is refused.
module frame_difference_variance_detector import fdv_pkg::*; #(
   parameter int MAX_PIXELS = 4194304,
   localparam int CNT_W = $clog2(MAX_PIXELS + 1),
   localparam int ABS_W = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1),
   localparam int SQ_W  = $clog2(64'(MAX_PIXELS) * 64'd65025 + 64'd1),
   localparam int TOT_W = CNT_W + ABS_W + SQ_W
) (
   input  logic             clock,
   input  logic             reset,
   fdv_req_if.sink          req_ch,
   fdv_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             q_push, q_pop, q_full, q_empty;
   logic [TOT_W-1:0] q_wdata, q_rdata;

   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   fdv_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_push (q_push),
      .q_data (q_wdata),
      .q_full (q_full)
   );

   fdv_queue #(.WIDTH(TOT_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   fdv_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .threshold (thr_ff),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("frame queue overflow");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("frame queue underflow");
   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_empty) |=> !q_empty)
      else $error("pushed frame lost");
`endif

endmodule
